// ===== hw/rtl/mpeg_audio_header_frame_length_assert.svh =====
// Assertion macros shared by the frame length block.
`ifndef MPEG_AUDIO_HEADER_FRAME_LENGTH_ASSERT_SVH
`define MPEG_AUDIO_HEADER_FRAME_LENGTH_ASSERT_SVH

// Checked at every rising clock edge outside reset.
`define MAFL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define MAFL_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/mafl_pkg.sv =====
package mafl_pkg;

   typedef struct packed {
      logic [7:0] header_byte_one;
      logic [7:0] header_byte_two;
   } req_type;

   typedef struct packed {
      logic        header_ok;
      logic [13:0] frame_bytes;
      logic [1:0]  layer_code;
      logic [1:0]  version_code;
      logic [1:0]  rate_index;
   } rsp_type;

   // Number of quotient bits, one divider cell each.
   localparam int QUOT_W = 12;
   localparam int NUM_W  = 26;
   localparam int REM_W  = 16;

   localparam logic [2:0] SYNC_BITS      = 3'b111;
   localparam logic [1:0] VER_MPEG1      = 2'd3;
   localparam logic [1:0] VER_RESERVED   = 2'd1;
   localparam logic [1:0] LAYER_I        = 2'd3;
   localparam logic [1:0] LAYER_II       = 2'd2;
   localparam logic [1:0] LAYER_RESERVED = 2'd0;
   localparam logic [3:0] BITRATE_FREE   = 4'd0;
   localparam logic [3:0] BITRATE_BAD    = 4'd15;
   localparam logic [1:0] RATE_RESERVED  = 2'd3;

   // Slot factor multiplied by 1000 so that kbit/s become bit/s.
   localparam logic [17:0] FACTOR_LAYER_I = 18'd12000;
   localparam logic [17:0] FACTOR_WIDE    = 18'd144000;
   localparam logic [17:0] FACTOR_NARROW  = 18'd72000;

   localparam logic [14:0] MIN_FRAME_BYTES = 15'd24;
   localparam logic [14:0] MAX_FRAME_BYTES = 15'd8192;

   // Bitrates in kbit/s, indexed by layer code and bitrate index.
   localparam logic [8:0] RATE_MPEG1 [4][16] = '{
      '{default: 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0}
   };

   localparam logic [8:0] RATE_MPEG2 [4][16] = '{
      '{default: 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0}
   };

   // Sample rates in Hz, indexed by version code and rate index.
   localparam logic [15:0] SAMPLE_HZ [4][4] = '{
      '{16'd11025, 16'd12000, 16'd8000, 16'd0},
      '{16'd0, 16'd0, 16'd0, 16'd0},
      '{16'd22050, 16'd24000, 16'd16000, 16'd0},
      '{16'd44100, 16'd48000, 16'd32000, 16'd0}
   };

   // One item on its way through the divider row.
   typedef struct packed {
      logic              ok;
      logic              pad;
      logic [1:0]        layer_code;
      logic [1:0]        version_code;
      logic [1:0]        rate_index;
      logic [REM_W-1:0]  divisor;
      logic [REM_W-1:0]  rem;
      logic [QUOT_W-1:0] num_low;
      logic [QUOT_W-1:0] quot;
   } div_item_type;

endpackage

// ===== hw/rtl/mpeg_audio_header_frame_length.sv =====
// MPEG audio frame length decoder. Each request carries the two header bytes that follow
// the 0xFF sync byte; each response says whether they form a valid header and, if so, the
// frame length in bytes (header included) together with the raw layer, version and sample
// rate codes, all fields being zero for a rejected header. One request is taken every clock
// cycle while req_stall is low. Each item passes through the front register for the table
// look-up and the bitrate multiplication, a row of identical restoring divider cells that
// each produce one quotient bit, and the output register for padding, the layer I slot size
// and the bounds check. Every stage holds its own item, so a stalled response only backs up
// the row as far as it is full.
`include "mpeg_audio_header_frame_length_assert.svh"

module mpeg_audio_header_frame_length
   import mafl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Stage k sits between divider cell k-1 and cell k; stage 0 is the front register.
   logic         stage_valid [QUOT_W+1];
   logic         stage_stall [QUOT_W+1];
   div_item_type stage_item  [QUOT_W+1];

   // The front stage decodes the header, looks up the rates and forms the numerator.
   mafl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (stage_valid[0]),
      .out_stall (stage_stall[0]),
      .out_item  (stage_item[0])
   );

   // The divider row: each cell brings down one numerator bit and yields one quotient bit.
   for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
      mafl_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_stall  (stage_stall[i]),
         .in_item   (stage_item[i]),
         .out_valid (stage_valid[i+1]),
         .out_stall (stage_stall[i+1]),
         .out_item  (stage_item[i+1])
      );
   end

   // The back stage finishes the length, checks its bounds and holds the response.
   mafl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[QUOT_W]),
      .in_stall  (stage_stall[QUOT_W]),
      .in_item   (stage_item[QUOT_W]),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   // The row only pushes back when the response side itself is holding a response.
   `MAFL_ASSERT(a_stall_from_output, req_stall |-> (rsp_valid && rsp_stall), "request stalled without output back-pressure")

   // An accepted request must be sitting in the front register in the following cycle.
   `MAFL_ASSERT(a_request_taken, ($past(req_valid && !req_stall) && !$past(reset)) |-> stage_valid[0], "accepted request lost at the front stage")

   // Nothing is offered in the cycle after reset.
   `MAFL_ASSERT_ALWAYS(a_quiet_after_reset, $past(reset) |-> !rsp_valid, "response offered straight after reset")

endmodule

// ===== hw/rtl/mafl_front.sv =====
module mafl_front
   import mafl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_stall,
   input  req_type      in_data,
   output logic         out_valid,
   input  logic         out_stall,
   output div_item_type out_item
);

   logic         valid_ff, valid_in;
   div_item_type item_ff, item_in;
   logic         advance;

   logic [1:0]       ver, lay, sri;
   logic [3:0]       bri;
   logic [8:0]       kbps;
   logic [15:0]      hz;
   logic [17:0]      factor;
   logic [26:0]      product;
   logic [NUM_W-1:0] num;
   logic             ok;

   assign advance  = !valid_ff || !out_stall;
   assign in_stall = !advance;
   assign valid_in = advance ? in_valid : valid_ff;

   always_comb begin
      ver = in_data.header_byte_one[4:3];
      lay = in_data.header_byte_one[2:1];
      bri = in_data.header_byte_two[7:4];
      sri = in_data.header_byte_two[3:2];

      kbps = (ver == VER_MPEG1) ? RATE_MPEG1[lay][bri] : RATE_MPEG2[lay][bri];
      hz   = SAMPLE_HZ[ver][sri];

      ok = (in_data.header_byte_one[7:5] == SYNC_BITS) && (ver != VER_RESERVED) &&
           (lay != LAYER_RESERVED) && (bri != BITRATE_FREE) && (bri != BITRATE_BAD) &&
           (sri != RATE_RESERVED) && (kbps != 9'd0) && (hz != 16'd0);

      if (lay == LAYER_I) begin
         factor = FACTOR_LAYER_I;
      end else if (ver == VER_MPEG1 || lay == LAYER_II) begin
         factor = FACTOR_WIDE;
      end else begin
         factor = FACTOR_NARROW;
      end

      product = 27'(kbps) * 27'(factor);
      num     = product[NUM_W-1:0];

      item_in              = item_ff;
      item_in.ok           = ok;
      item_in.pad          = in_data.header_byte_two[1];
      item_in.layer_code   = lay;
      item_in.version_code = ver;
      item_in.rate_index   = sri;
      item_in.divisor      = hz;
      // The top bits of the numerator are already below the divisor for every legal header.
      item_in.rem          = REM_W'(num[NUM_W-1:QUOT_W]);
      item_in.num_low      = num[QUOT_W-1:0];
      item_in.quot         = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== hw/rtl/mafl_div_cell.sv =====
module mafl_div_cell
   import mafl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_stall,
   input  div_item_type in_item,
   output logic         out_valid,
   input  logic         out_stall,
   output div_item_type out_item
);

   logic         valid_ff, valid_in;
   div_item_type item_ff, item_in;
   logic         advance;
   logic [REM_W:0] trial, diff;
   logic           take;

   assign advance  = !valid_ff || !out_stall;
   assign in_stall = !advance;
   assign valid_in = advance ? in_valid : valid_ff;

   // One restoring division step: bring down the next numerator bit and subtract if it fits.
   always_comb begin
      trial = {in_item.rem, in_item.num_low[QUOT_W-1]};
      diff  = trial - {1'b0, in_item.divisor};
      take  = (trial >= {1'b0, in_item.divisor});

      item_in         = in_item;
      item_in.rem     = take ? diff[REM_W-1:0] : trial[REM_W-1:0];
      item_in.num_low = {in_item.num_low[QUOT_W-2:0], 1'b0};
      item_in.quot    = {in_item.quot[QUOT_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== hw/rtl/mafl_back.sv =====
module mafl_back
   import mafl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_stall,
   input  div_item_type in_item,
   output logic         out_valid,
   input  logic         out_stall,
   output rsp_type      out_data
);

   logic        valid_ff, valid_in;
   rsp_type     data_ff, data_in;
   logic        advance;
   logic [12:0] slot;
   logic [14:0] len;
   logic        good;

   assign advance  = !valid_ff || !out_stall;
   assign in_stall = !advance;
   assign valid_in = advance ? in_valid : valid_ff;

   always_comb begin
      slot = 13'(in_item.quot) + 13'(in_item.pad);
      // Layer I counts in four-byte slots.
      len  = (in_item.layer_code == LAYER_I) ? {slot, 2'b00} : 15'(slot);
      good = in_item.ok && (len >= MIN_FRAME_BYTES) && (len <= MAX_FRAME_BYTES);

      data_in = '0;
      if (good) begin
         data_in.header_ok    = 1'b1;
         data_in.frame_bytes  = len[13:0];
         data_in.layer_code   = in_item.layer_code;
         data_in.version_code = in_item.version_code;
         data_in.rate_index   = in_item.rate_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
